// ===== sv/wavhp_pkg.sv =====
// Shared types and constants for the RIFF/WAVE header parser.
package wavhp_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CONTAINER = 2'd1;
    localparam logic [1:0] ST_ENCODING  = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    // Four-character codes as they appear little-endian in the byte shifter
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Encoding codes
    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    // Frame byte count is channels (16 bits) times 2..4 bytes
    localparam int FRAME_W = 18;

    // Default depth of the queue between parser and finisher
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [32:0] data_offset;
        logic [31:0] data_size;
        logic [31:0] frame_total;
    } out_item_t;

    // One parsed file, handed from the parser to the finisher
    typedef struct packed {
        logic [1:0]  err;
        logic        phase_bad;
        logic        fmt_seen;
        logic        data_seen;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [32:0] data_offset;
        logic [31:0] data_size;
    } job_t;

endpackage

// ===== sv/wavhp_front.sv =====
// Byte-at-a-time RIFF/WAVE chunk walker; emits one job per file.
module wavhp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  wavhp_pkg::in_item_t  item,
    output logic                 push,
    output wavhp_pkg::job_t      job
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_SIZE   = 3'd2;
    localparam logic [2:0] PH_FMT    = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;

    logic [2:0]  phase_reg,     phase_next;
    logic [3:0]  lane_reg,      lane_next;
    logic [32:0] pos_reg,       pos_next;
    logic [31:0] shift_reg,     shift_next;
    logic [31:0] tag_reg,       tag_next;
    logic [32:0] skip_reg,      skip_next;
    logic        fmt_seen_reg,  fmt_seen_next;
    logic        data_seen_reg, data_seen_next;
    logic [1:0]  err_reg,       err_next;
    logic [15:0] ftag_reg,      ftag_next;
    logic [15:0] chan_reg,      chan_next;
    logic [31:0] rate_reg,      rate_next;
    logic [15:0] bits_reg,      bits_next;
    logic [32:0] doff_reg,      doff_next;
    logic [31:0] dsize_reg,     dsize_next;

    logic [32:0] padded;
    logic [32:0] skip_dec;
    logic [32:0] pos_inc;

    assign padded   = {1'b0, shift_next} + {32'd0, shift_next[0]};
    assign skip_dec = skip_reg - 33'd1;
    assign pos_inc  = pos_reg + 33'd1;

    // Per-byte parse step
    always_comb
    begin
        phase_next     = phase_reg;
        lane_next      = lane_reg;
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        tag_next       = tag_reg;
        skip_next      = skip_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        err_next       = err_reg;
        ftag_next      = ftag_reg;
        chan_next      = chan_reg;
        rate_next      = rate_reg;
        bits_next      = bits_reg;
        doff_next      = doff_reg;
        dsize_next     = dsize_reg;

        if (take)
        begin
            pos_next = pos_inc;
            if (err_reg == wavhp_pkg::ST_OK)
            begin
                shift_next = {item.file_byte, shift_reg[31:8]};
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (lane_reg == 4'd3)
                            tag_next = shift_next;
                        if (lane_reg == 4'd11)
                        begin
                            if (tag_reg != wavhp_pkg::TAG_RIFF ||
                                shift_next != wavhp_pkg::TAG_WAVE)
                                err_next = wavhp_pkg::ST_CONTAINER;
                            phase_next = PH_ID;
                            lane_next  = 4'd0;
                        end
                        else
                            lane_next = lane_reg + 4'd1;
                    end
                    PH_SIZE:
                    begin
                        if (lane_reg == 4'd3)
                        begin
                            if (tag_reg == wavhp_pkg::TAG_FMT)
                            begin
                                if (shift_next < 32'd16)
                                    err_next = wavhp_pkg::ST_MALFORMED;
                                else
                                begin
                                    skip_next  = padded - 33'd16;
                                    phase_next = PH_FMT;
                                    lane_next  = 4'd0;
                                end
                            end
                            else
                            begin
                                if (tag_reg == wavhp_pkg::TAG_DATA)
                                begin
                                    doff_next      = pos_inc;
                                    dsize_next     = shift_next;
                                    data_seen_next = 1'b1;
                                end
                                skip_next  = padded;
                                lane_next  = 4'd0;
                                phase_next = (padded == 33'd0) ? PH_ID : PH_SKIP;
                            end
                        end
                        else
                            lane_next = lane_reg + 4'd1;
                    end
                    PH_FMT:
                    begin
                        if (lane_reg == 4'd1)
                            ftag_next = shift_next[31:16];
                        if (lane_reg == 4'd3)
                            chan_next = shift_next[31:16];
                        if (lane_reg == 4'd7)
                            rate_next = shift_next;
                        if (lane_reg == 4'd15)
                        begin
                            bits_next     = shift_next[31:16];
                            fmt_seen_next = 1'b1;
                            lane_next     = 4'd0;
                            phase_next    = (skip_reg == 33'd0) ? PH_ID : PH_SKIP;
                        end
                        else
                            lane_next = lane_reg + 4'd1;
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 33'd0)
                        begin
                            lane_next  = 4'd0;
                            phase_next = PH_ID;
                        end
                    end
                    default:
                    begin
                        if (lane_reg == 4'd3)
                        begin
                            tag_next   = shift_next;
                            phase_next = PH_SIZE;
                            lane_next  = 4'd0;
                        end
                        else
                        begin
                            phase_next = PH_ID;
                            lane_next  = lane_reg + 4'd1;
                        end
                    end
                endcase
            end
        end
    end

    // Job snapshot from the state after the final byte
    always_comb
    begin
        job.err         = err_next;
        job.phase_bad   = (phase_next == PH_HEADER) || (phase_next == PH_SIZE) ||
                          (phase_next == PH_FMT);
        job.fmt_seen    = fmt_seen_next;
        job.data_seen   = data_seen_next;
        job.format_tag  = ftag_next;
        job.channels    = chan_next;
        job.rate        = rate_next;
        job.bits        = bits_next;
        job.data_offset = doff_next;
        job.data_size   = dsize_next;
    end

    assign push = take & item.end_of_file;

    // Parser state; the final byte of a file returns it to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n || 1'b0)
        begin
            phase_reg     <= PH_HEADER;
            lane_reg      <= 4'd0;
            pos_reg       <= 33'd0;
            shift_reg     <= 32'd0;
            tag_reg       <= 32'd0;
            skip_reg      <= 33'd0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            err_reg       <= wavhp_pkg::ST_OK;
            ftag_reg      <= 16'd0;
            chan_reg      <= 16'd0;
            rate_reg      <= 32'd0;
            bits_reg      <= 16'd0;
            doff_reg      <= 33'd0;
            dsize_reg     <= 32'd0;
        end
        else if (push)
        begin
            phase_reg     <= PH_HEADER;
            lane_reg      <= 4'd0;
            pos_reg       <= 33'd0;
            shift_reg     <= 32'd0;
            tag_reg       <= 32'd0;
            skip_reg      <= 33'd0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            err_reg       <= wavhp_pkg::ST_OK;
            ftag_reg      <= 16'd0;
            chan_reg      <= 16'd0;
            rate_reg      <= 32'd0;
            bits_reg      <= 16'd0;
            doff_reg      <= 33'd0;
            dsize_reg     <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            lane_reg      <= lane_next;
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            tag_reg       <= tag_next;
            skip_reg      <= skip_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            err_reg       <= err_next;
            ftag_reg      <= ftag_next;
            chan_reg      <= chan_next;
            rate_reg      <= rate_next;
            bits_reg      <= bits_next;
            doff_reg      <= doff_next;
            dsize_reg     <= dsize_next;
        end
    end

endmodule

// ===== sv/wavhp_queue.sv =====
// Small first-in first-out job queue between parser and finisher.
module wavhp_queue
#(
    parameter int DEPTH = wavhp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wavhp_pkg::job_t  push_job,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output wavhp_pkg::job_t  head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wavhp_pkg::job_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== sv/wavhp_back.sv =====
// Final checks, frame-count division and the registered result item.
module wavhp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  wavhp_pkg::job_t       job,
    output logic                  job_pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output wavhp_pkg::out_item_t  result_item
);

    localparam int FW = wavhp_pkg::FRAME_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg,  state_next;
    logic [4:0]        cnt_reg,    cnt_next;
    logic [1:0]        st_reg,     st_next;
    logic [FW-1:0]     div_reg,    div_next;
    logic [FW-1:0]     rem_reg,    rem_next;
    logic [31:0]       quo_reg,    quo_next;
    wavhp_pkg::job_t   hold_reg,   hold_next;
    logic              oval_reg,   oval_next;
    wavhp_pkg::out_item_t oitem_reg, oitem_next;

    logic [1:0]    pre_st;
    logic          enc_ok;
    logic [18:0]   frame_prod;
    logic [FW:0]   rem_w;
    logic          ge;
    logic [1:0]    fin_st;
    logic          out_free;

    // Checks on the queue head, in priority order
    always_comb
    begin
        enc_ok = ((job.format_tag == wavhp_pkg::FMT_PCM) &&
                  (job.bits == 16'd16 || job.bits == 16'd24 || job.bits == 16'd32)) ||
                 ((job.format_tag == wavhp_pkg::FMT_FLOAT) && (job.bits == 16'd32));
        pre_st = job.err;
        if (pre_st == wavhp_pkg::ST_OK && job.phase_bad)
            pre_st = wavhp_pkg::ST_MALFORMED;
        if (pre_st == wavhp_pkg::ST_OK &&
            (!job.fmt_seen || !job.data_seen || job.channels == 16'd0 || job.rate == 32'd0))
            pre_st = wavhp_pkg::ST_MALFORMED;
        if (pre_st == wavhp_pkg::ST_OK && !enc_ok)
            pre_st = wavhp_pkg::ST_ENCODING;
    end

    // Bytes per frame: bits is 16, 24 or 32 here, so bits / 8 is bits[5:3]
    assign frame_prod = job.channels * job.bits[5:3];

    // One restoring division step
    assign rem_w = {rem_reg, quo_reg[31]};
    assign ge    = (rem_w >= {1'b0, div_reg});

    assign fin_st   = (st_reg == wavhp_pkg::ST_OK && rem_reg != '0) ?
                      wavhp_pkg::ST_MALFORMED : st_reg;
    assign out_free = ~oval_reg | ~result_stall;
    assign job_pop  = (state_reg == S_IDLE) & job_valid;

    // Finisher sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        hold_next  = hold_reg;
        oval_next  = oval_reg & result_stall;
        oitem_next = oitem_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    hold_next = job;
                    st_next   = pre_st;
                    div_next  = frame_prod[FW-1:0];
                    rem_next  = '0;
                    quo_next  = job.data_size;
                    cnt_next  = 5'd0;
                    state_next = (pre_st == wavhp_pkg::ST_OK) ? S_DIV : S_DONE;
                end
            end
            S_DIV:
            begin
                rem_next = ge ? FW'(rem_w - {1'b0, div_reg}) : rem_w[FW-1:0];
                quo_next = {quo_reg[30:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    oval_next = 1'b1;
                    oitem_next = '0;
                    oitem_next.status = fin_st;
                    if (fin_st == wavhp_pkg::ST_OK)
                    begin
                        oitem_next.format_tag    = hold_reg.format_tag;
                        oitem_next.channel_count = hold_reg.channels;
                        oitem_next.sample_rate   = hold_reg.rate;
                        oitem_next.sample_bits   = hold_reg.bits;
                        oitem_next.data_offset   = hold_reg.data_offset;
                        oitem_next.data_size     = hold_reg.data_size;
                        oitem_next.frame_total   = quo_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        st_reg    <= st_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        hold_reg  <= hold_next;
        oitem_reg <= oitem_next;
    end

    assign result_valid = oval_reg;
    assign result_item  = oitem_reg;

endmodule

// ===== sv/wav_header_parser.sv =====
// Path: the result follows the end_of_file byte through the job queue and, when all checks
// pass, the 32-step restoring divider for the frame count, then the output register.
// Throughput: one file byte per cycle while the job queue is not full; the finisher takes
// a new job only when idle, and the queue holds files that arrive meanwhile until it fills.
// Reset: rst_n asynchronous, active low; clears the parser, queue and output valid.
// Top level of the RIFF/WAVE header parser.
module wav_header_parser
#(
    parameter int QUEUE_DEPTH = wavhp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  wavhp_pkg::in_item_t   byte_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output wavhp_pkg::out_item_t  result_item
);

    logic            q_full;
    logic            take;
    logic            push;
    wavhp_pkg::job_t push_job;
    logic            pop;
    logic            head_valid;
    wavhp_pkg::job_t head_job;

    assign byte_stall = q_full;
    assign take       = byte_valid & ~q_full;

    wavhp_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (byte_item),
        .push  (push),
        .job   (push_job)
    );

    wavhp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    wavhp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (head_valid),
        .job          (head_job),
        .job_pop      (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ===== tb/wav_scan_checker.sv =====
// Checker for the WAV header parser: tracks accepted bytes, predicts each file summary, compares.
module wav_scan_checker
    import wavhp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    input  logic      byte_stall,
    input  in_item_t  byte_item,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_item_t result_item,
    output int        fail_count,
    output int        files_in_flight,
    output int        file_count,
    output int        clean_count,
    output int        backpressure_cycles
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_CHUNK_ID,
        SCAN_CHUNK_SIZE,
        SCAN_FMT_BODY,
        SCAN_SKIP
    } scan_state_t;

    // Shadow copy of the parser state
    scan_state_t scan_state;
    logic [32:0] file_pos;
    logic [31:0] shifter;
    logic [31:0] cur_tag;
    logic [32:0] bytes_to_skip;
    logic        have_fmt;
    logic        have_data;
    logic [1:0]  first_error;
    logic [15:0] fmt_tag;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_bits;
    logic [32:0] payload_offset;
    logic [31:0] payload_size;
    logic [4:0]  field_idx;

    // File summaries waiting for the block to report them
    out_item_t parsed_files[$];

    int fail_total = 0;
    int result_total = 0;
    int ok_total = 0;
    int stall_total = 0;

    assign fail_count          = fail_total;
    assign files_in_flight     = parsed_files.size();
    assign file_count          = result_total;
    assign clean_count         = ok_total;
    assign backpressure_cycles = stall_total;

    task automatic flag_mismatch(input string msg);
        fail_total++;
        if (fail_total <= 40)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    function automatic void clear_scan();
        scan_state     = SCAN_HEADER;
        file_pos       = '0;
        shifter        = '0;
        cur_tag        = '0;
        bytes_to_skip  = '0;
        have_fmt       = 1'b0;
        have_data      = 1'b0;
        first_error    = ST_OK;
        fmt_tag        = '0;
        fmt_channels   = '0;
        fmt_rate       = '0;
        fmt_bits       = '0;
        payload_offset = '0;
        payload_size   = '0;
        field_idx      = '0;
    endfunction

    function automatic void enter_next_chunk();
        field_idx  = '0;
        scan_state = (bytes_to_skip == '0) ? SCAN_CHUNK_ID : SCAN_SKIP;
    endfunction

    // Advance the shadow parser by one byte; on the last byte of a file queue its summary
    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [32:0] padded;
        logic [63:0] frame_bytes;
        logic [1:0]  status;
        out_item_t   summary;
        if (first_error == ST_OK)
        begin
            shifter = {b, shifter[31:8]};
            case (scan_state)
                SCAN_HEADER:
                begin
                    if (field_idx == 5'd3)
                        cur_tag = shifter;
                    if (field_idx == 5'd11)
                    begin
                        if (cur_tag != TAG_RIFF || shifter != TAG_WAVE)
                            first_error = ST_CONTAINER;
                        scan_state = SCAN_CHUNK_ID;
                        field_idx  = '0;
                    end
                    else
                        field_idx++;
                end
                SCAN_CHUNK_SIZE:
                begin
                    if (field_idx == 5'd3)
                    begin
                        // odd sizes carry a pad byte; 33 bits so the maximum never wraps
                        padded = {1'b0, shifter} + {32'd0, shifter[0]};
                        if (cur_tag == TAG_FMT)
                        begin
                            if (shifter < 32'd16)
                                first_error = ST_MALFORMED;
                            else
                            begin
                                bytes_to_skip = padded - 33'd16;
                                scan_state    = SCAN_FMT_BODY;
                                field_idx     = '0;
                            end
                        end
                        else
                        begin
                            if (cur_tag == TAG_DATA)
                            begin
                                payload_offset = file_pos + 33'd1;
                                payload_size   = shifter;
                                have_data      = 1'b1;
                            end
                            bytes_to_skip = padded;
                            enter_next_chunk();
                        end
                    end
                    else
                        field_idx++;
                end
                SCAN_FMT_BODY:
                begin
                    if (field_idx == 5'd1)
                        fmt_tag = shifter[31:16];
                    if (field_idx == 5'd3)
                        fmt_channels = shifter[31:16];
                    if (field_idx == 5'd7)
                        fmt_rate = shifter;
                    if (field_idx == 5'd15)
                    begin
                        fmt_bits = shifter[31:16];
                        have_fmt = 1'b1;
                        enter_next_chunk();
                    end
                    else
                        field_idx++;
                end
                SCAN_SKIP:
                begin
                    bytes_to_skip = bytes_to_skip - 33'd1;
                    if (bytes_to_skip == '0)
                        enter_next_chunk();
                end
                default:
                begin
                    if (field_idx == 5'd3)
                    begin
                        cur_tag    = shifter;
                        scan_state = SCAN_CHUNK_SIZE;
                        field_idx  = '0;
                    end
                    else
                        field_idx++;
                end
            endcase
        end
        file_pos = file_pos + 33'd1;

        if (last)
        begin
            // a cut chunk id or a skip past the end is fine; other cuts are malformed
            status = first_error;
            if (status == ST_OK && (scan_state == SCAN_HEADER ||
                                    scan_state == SCAN_CHUNK_SIZE ||
                                    scan_state == SCAN_FMT_BODY))
                status = ST_MALFORMED;
            if (status == ST_OK && (!have_fmt || !have_data ||
                                    fmt_channels == '0 || fmt_rate == '0))
                status = ST_MALFORMED;
            if (status == ST_OK &&
                !((fmt_tag == FMT_PCM &&
                   (fmt_bits == 16'd16 || fmt_bits == 16'd24 || fmt_bits == 16'd32)) ||
                  (fmt_tag == FMT_FLOAT && fmt_bits == 16'd32)))
                status = ST_ENCODING;
            frame_bytes = 64'(fmt_channels) * 64'(fmt_bits / 16'd8);
            if (status == ST_OK && (frame_bytes == '0 || 64'(payload_size) % frame_bytes != '0))
                status = ST_MALFORMED;

            summary = '0;
            summary.status = status;
            if (status == ST_OK)
            begin
                summary.format_tag    = fmt_tag;
                summary.channel_count = fmt_channels;
                summary.sample_rate   = fmt_rate;
                summary.sample_bits   = fmt_bits;
                summary.data_offset   = payload_offset;
                summary.data_size     = payload_size;
                summary.frame_total   = 32'(64'(payload_size) / frame_bytes);
            end
            parsed_files.push_back(summary);
            clear_scan();
        end
    endtask

    // Compare one reported summary with the oldest prediction
    task automatic check_result(input out_item_t got);
        out_item_t want;
        result_total++;
        if (parsed_files.size() == 0)
            flag_mismatch($sformatf("result %0d arrived with no file pending", result_total));
        else
        begin
            want = parsed_files.pop_front();
            if (want.status == ST_OK)
                ok_total++;
            if (got.status !== want.status)
                flag_mismatch($sformatf("file %0d status got %0h expected %0h",
                    result_total, got.status, want.status));
            if (got.format_tag !== want.format_tag)
                flag_mismatch($sformatf("file %0d format_tag got %0h expected %0h",
                    result_total, got.format_tag, want.format_tag));
            if (got.channel_count !== want.channel_count)
                flag_mismatch($sformatf("file %0d channel_count got %0h expected %0h",
                    result_total, got.channel_count, want.channel_count));
            if (got.sample_rate !== want.sample_rate)
                flag_mismatch($sformatf("file %0d sample_rate got %0h expected %0h",
                    result_total, got.sample_rate, want.sample_rate));
            if (got.sample_bits !== want.sample_bits)
                flag_mismatch($sformatf("file %0d sample_bits got %0h expected %0h",
                    result_total, got.sample_bits, want.sample_bits));
            if (got.data_offset !== want.data_offset)
                flag_mismatch($sformatf("file %0d data_offset got %0h expected %0h",
                    result_total, got.data_offset, want.data_offset));
            if (got.data_size !== want.data_size)
                flag_mismatch($sformatf("file %0d data_size got %0h expected %0h",
                    result_total, got.data_size, want.data_size));
            if (got.frame_total !== want.frame_total)
                flag_mismatch($sformatf("file %0d frame_total got %0h expected %0h",
                    result_total, got.frame_total, want.frame_total));
        end
    endtask

    // Watch both channels; results are checked before the same edge's byte is absorbed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            parsed_files.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result_item);
            if (byte_valid && byte_stall)
                stall_total++;
            if (byte_valid && !byte_stall)
                scan_byte(byte_item.file_byte, byte_item.end_of_file);
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the WAV header parser testbench: builds byte streams, drives flow control, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wavhp_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BYTES  = 400;
    localparam int RANDOM_FILES  = 48;
    localparam int QUIET_FILES   = 8;
    localparam int DRAIN_CYCLES  = 60;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;

    // Ways a mostly well-formed file can be spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_TAG,
        FLAW_BITS,
        FLAW_NO_CHANNELS,
        FLAW_NO_RATE,
        FLAW_ODD_SIZE,
        FLAW_NO_FMT,
        FLAW_NO_DATA,
        FLAW_REPEAT,
        FLAW_DATA_FIRST
    } flaw_t;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result_item;

    int fail_count;
    int files_in_flight;
    int file_count;
    int clean_count;
    int backpressure_cycles;

    logic [7:0] wave_bytes[$];
    bit quiet_phase = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    int sent_bytes  = 0;

    wav_header_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    wav_scan_checker scan_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .byte_valid          (byte_valid),
        .byte_stall          (byte_stall),
        .byte_item           (byte_item),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .result_item         (result_item),
        .fail_count          (fail_count),
        .files_in_flight     (files_in_flight),
        .file_count          (file_count),
        .clean_count         (clean_count),
        .backpressure_cycles (backpressure_cycles)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // File building helpers, little-endian as in the container
    task automatic put_le(input logic [31:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            wave_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic put_random(input int n);
        repeat (n) wave_bytes.push_back(8'($urandom));
    endtask

    task automatic put_riff_header();
        put_le(TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(TAG_WAVE, 4);
    endtask

    task automatic put_fmt_chunk(input logic [15:0] tag, input logic [15:0] chans,
                                 input logic [31:0] rate, input logic [15:0] bits,
                                 input logic [31:0] size);
        put_le(TAG_FMT, 4);
        put_le(size, 4);
        put_le(tag, 2);
        put_le(chans, 2);
        put_le(rate, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le(bits, 2);
        // extension bytes plus pad, only for modest sizes
        if (size > 32'd16 && size <= 32'd64)
            put_random(int'(size) - 16 + int'(size[0]));
    endtask

    task automatic put_data_chunk(input logic [31:0] size, input int body);
        put_le(TAG_DATA, 4);
        put_le(size, 4);
        put_random(body);
    endtask

    task automatic put_other_chunk(input logic [31:0] size, input int body);
        put_le(TAG_LIST, 4);
        put_le(size, 4);
        put_random(body);
    endtask

    task automatic truncate_wave(input int n);
        while (wave_bytes.size() > n)
            void'(wave_bytes.pop_back());
    endtask

    // A plausible file with random content and at most one flaw
    task automatic build_valid_wave(input flaw_t flaw);
        logic [15:0] tag;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] frame;
        logic [31:0] dsize;
        logic [31:0] fsize;
        int pick;
        int body;
        pick  = $urandom_range(0, 3);
        tag   = (pick == 3) ? FMT_FLOAT : FMT_PCM;
        bits  = (pick == 0) ? 16'd16 : (pick == 1) ? 16'd24 : 16'd32;
        chans = ($urandom_range(0, 5) == 0) ? (16'($urandom) | 16'd1)
                                             : 16'($urandom_range(1, 8));
        rate  = ($urandom_range(0, 1) == 1) ? 32'd48000 : ($urandom | 32'd1);
        frame = 32'(chans) * 32'(bits / 16'd8);
        dsize = frame * $urandom_range(0, 3);
        if ($urandom_range(0, 5) == 0 && flaw != FLAW_DATA_FIRST)
            dsize = (32'hFFFF_FFFF / frame) * frame;
        fsize = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(17, 22)) : 32'd16;
        case (flaw)
            FLAW_TAG:         tag   = 16'($urandom);
            FLAW_BITS:        bits  = 16'($urandom_range(0, 40));
            FLAW_NO_CHANNELS: chans = '0;
            FLAW_NO_RATE:     rate  = '0;
            FLAW_ODD_SIZE:    dsize = dsize + 32'd1;
            default:          ;
        endcase

        put_riff_header();
        if ($urandom_range(0, 2) == 0)
        begin
            body = $urandom_range(0, 5);
            put_other_chunk(32'(body), body + body % 2);
        end
        // earlier chunks that the later ones must overwrite
        if (flaw == FLAW_REPEAT)
        begin
            put_fmt_chunk(16'($urandom), 16'($urandom), $urandom, 16'($urandom), 32'd16);
            body = $urandom_range(0, 4);
            put_data_chunk(32'(body), body + body % 2);
        end
        if (flaw == FLAW_DATA_FIRST)
            put_data_chunk(dsize, int'(dsize) + int'(dsize[0]));
        if (flaw != FLAW_NO_FMT)
            put_fmt_chunk(tag, chans, rate, bits, fsize);
        if (flaw != FLAW_NO_DATA && flaw != FLAW_DATA_FIRST)
        begin
            if (dsize <= 32'd12)
            begin
                put_data_chunk(dsize, int'(dsize) + int'(dsize[0]));
                // then nothing, a whole chunk, or a cut chunk id
                case ($urandom_range(0, 2))
                    0:       put_random($urandom_range(1, 3));
                    1:       put_other_chunk(32'd2, 2);
                    default: ;
                endcase
            end
            else
                put_data_chunk(dsize, $urandom_range(0, 6));
        end
    endtask

    task automatic build_random_wave();
        int kind;
        int idx;
        kind = $urandom_range(0, 19);
        if (kind < 10)
            build_valid_wave(FLAW_NONE);
        else if (kind < 13)
            build_valid_wave(flaw_t'($urandom_range(FLAW_TAG, FLAW_DATA_FIRST)));
        else if (kind < 16)
        begin
            // cut anywhere: short header, cut id, cut size, short fmt, skip past end
            build_valid_wave(($urandom_range(0, 1) == 1) ? FLAW_NONE : FLAW_REPEAT);
            truncate_wave($urandom_range(1, wave_bytes.size()));
        end
        else if (kind < 17)
        begin
            // one bit wrong in RIFF or WAVE
            build_valid_wave(FLAW_NONE);
            idx = $urandom_range(0, 7);
            if (idx >= 4)
                idx += 4;
            wave_bytes[idx] = wave_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
        end
        else if (kind < 18)
        begin
            put_riff_header();
            put_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'($urandom_range(0, 15)));
            put_random($urandom_range(0, 8));
        end
        else if (kind < 19)
        begin
            // odd maximal sizes
            put_riff_header();
            if ($urandom_range(0, 1) == 1)
                put_other_chunk(32'hFFFF_FFFF, $urandom_range(0, 5));
            else
                put_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'hFFFF_FFFF);
            put_random($urandom_range(0, 4));
        end
        else
            put_random($urandom_range(1, 24));
    endtask

    // Offer one byte and hold it until accepted; idle bursts come before the offer
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 6);
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item.file_byte   <= b;
        byte_item.end_of_file <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_wave();
        foreach (wave_bytes[i])
            send_byte(wave_bytes[i], i == wave_bytes.size() - 1);
        wave_bytes.delete();
    endtask

    // Receiver: random stall bursts, one long hold on request, none at the end
    initial
    begin
        int gap;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 6);
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int random_files;
        int random_start;
        random_files = 0;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header cut short
        put_le(TAG_RIFF, 4);
        put_random(1);
        send_wave();
        // wrong form type
        put_le(TAG_RIFF, 4);
        put_le(32'hFFFF_FFFF, 4);
        put_le(TAG_FMT, 4);
        send_wave();
        // field extremes: float, all channels, top rate, empty data
        put_riff_header();
        put_fmt_chunk(FMT_FLOAT, 16'hFFFF, 32'hFFFF_FFFF, 16'd32, 32'd16);
        put_data_chunk(32'd0, 0);
        send_wave();
        // padded odd chunks, 24-bit mono, trailing cut chunk id
        put_riff_header();
        put_other_chunk(32'd3, 4);
        put_fmt_chunk(FMT_PCM, 16'd1, 32'd8000, 16'd24, 32'd17);
        put_data_chunk(32'd9, 10);
        put_random(2);
        send_wave();
        // data declared larger than the file
        put_riff_header();
        put_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd16);
        put_data_chunk(32'hFFFF_FFFC, 3);
        send_wave();
        // maximal odd size, pad pushes the count past 32 bits
        put_riff_header();
        put_other_chunk(32'hFFFF_FFFF, 2);
        send_wave();
        // fmt size below 16
        put_riff_header();
        put_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd15);
        send_wave();
        // cut inside the chunk size, then inside the fmt body
        put_riff_header();
        put_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd16);
        truncate_wave(18);
        send_wave();
        put_riff_header();
        put_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd16);
        truncate_wave(28);
        send_wave();
        // 8-bit PCM is not supported
        put_riff_header();
        put_fmt_chunk(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd16);
        put_data_chunk(32'd2, 2);
        send_wave();
        // each flaw once
        for (int f = FLAW_TAG; f <= FLAW_DATA_FIRST; f++)
        begin
            build_valid_wave(flaw_t'(f));
            send_wave();
        end

        // long receiver hold while tiny files pile up in the block
        hold_req = 1'b1;
        repeat (12)
        begin
            put_random($urandom_range(1, 2));
            send_wave();
        end

        // random files, quiet flow control at the end
        random_start = sent_bytes;
        while (random_files < RANDOM_FILES || sent_bytes - random_start < RANDOM_BYTES)
        begin
            if (random_files >= RANDOM_FILES - QUIET_FILES)
                quiet_phase = 1'b1;
            build_random_wave();
            send_wave();
            random_files++;
        end
        byte_valid <= 1'b0;

        while (files_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Parsed %0d files (%0d well formed) from %0d bytes; input held off %0d cycles.",
                 file_count, clean_count, sent_bytes, backpressure_cycles);
        $display("Covered bad containers, truncations, small fmt, huge sizes, bad encodings: %0d errors.",
                 fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
